// ----- sv/ssc_pkg.sv -----
// Shared types, widths, register indexes and reset values for the stereo sustain compressor.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ssc_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int FRAC_BITS_DEF = 24;
    localparam int VALUE_W       = 32;
    localparam int TIMER_W       = 17;
    localparam int STEP_W        = 6;

    localparam int GAIN_W    = 31;
    localparam int LEVEL_W   = 25;
    localparam int THRESH_W  = 26;
    localparam int RATIO_W   = 26;
    localparam int RELEASE_W = 25;
    localparam int ALPHA_W   = 25;
    localparam int HOLD_W    = 16;

    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LEVEL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_THRESHOLD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_RATIO = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_RELEASE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ENVELOPE_ALPHA  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SAMPLES    = 3'd6;

    localparam logic [GAIN_W-1:0]    INPUT_GAIN_RST      = 31'd96130000;
    localparam logic [LEVEL_W-1:0]   OUTPUT_LEVEL_RST    = 25'd3020000;
    localparam logic [THRESH_W-1:0]  BASE_THRESHOLD_RST  = 26'd12649000;
    localparam logic [RATIO_W-1:0]   THRESHOLD_RATIO_RST = 26'd12515000;
    localparam logic [RELEASE_W-1:0] PEAK_RELEASE_RST    = 25'd16742000;
    localparam logic [ALPHA_W-1:0]   ENVELOPE_ALPHA_RST  = 25'd6987;
    localparam logic [HOLD_W-1:0]    HOLD_SAMPLES_RST    = 16'd600;

    typedef struct packed {
        logic [GAIN_W-1:0]    input_gain;
        logic [LEVEL_W-1:0]   output_level;
        logic [THRESH_W-1:0]  base_threshold;
        logic [RATIO_W-1:0]   threshold_ratio;
        logic [RELEASE_W-1:0] peak_release;
        logic [ALPHA_W-1:0]   envelope_alpha;
        logic [HOLD_W-1:0]    hold_samples;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } ssc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } ssc_out_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } ssc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ssc_stat_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] rem_init;
        logic [VALUE_W-1:0] num_low;
        logic [VALUE_W-1:0] divisor;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [VALUE_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/stereo_sustain_compressor.sv -----
// Stereo sustain compressor top level: configuration registers, handshakes, output register.
// Depends on ssc_pkg; instantiates ssc_core (which holds ssc_div).
//
// Input channel in_valid/in_stall/in_data carries one stereo pair; a transfer happens on a
// rising edge with in_valid high and in_stall low. Output channel out_valid/out_stall/out_data
// carries the compressed pair the same way, from an output register.
// The block works on one pair at a time; in_stall stays high while a pair is in progress.
// out_valid rises after the input transfer; the path is longer when the envelope exceeds the
// threshold and the block compresses than when it stays at or below it. The next pair can be
// taken once the core is back in idle. The two restoring divisions in the shared divider
// (32 and FRAC_BITS steps) make the compressing path longer; the fifteen sequencer states
// around the shared multiplier make up the other path.
// A new pair may be taken while a finished result waits in the output register. If the
// receiver stalls and the register is still full when the next result is ready, the core
// holds that result and keeps in_stall high until the register frees.
// Registers are written through cfg_write/cfg_index/cfg_data; the user is to write them only
// while the block is idle, which the block does not enforce itself. Indexes without a register
// are ignored. Reset restores register defaults, clears peak, envelope and hold timer, sets the
// dynamic threshold to the default base threshold and empties the output register.
`default_nettype none

module stereo_sustain_compressor #(
    parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire ssc_pkg::ssc_in_t                  in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output ssc_pkg::ssc_out_t                      out_data,
    input  wire logic                              cfg_write,
    input  wire logic [ssc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ssc_pkg::cfg_t      cfg_reg;
    ssc_pkg::ssc_ctrl_t ctrl;
    ssc_pkg::ssc_stat_t stat;
    ssc_pkg::ssc_out_t  core_result;
    ssc_pkg::ssc_out_t  out_data_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{input_gain:      ssc_pkg::INPUT_GAIN_RST,
                         output_level:    ssc_pkg::OUTPUT_LEVEL_RST,
                         base_threshold:  ssc_pkg::BASE_THRESHOLD_RST,
                         threshold_ratio: ssc_pkg::THRESHOLD_RATIO_RST,
                         peak_release:    ssc_pkg::PEAK_RELEASE_RST,
                         envelope_alpha:  ssc_pkg::ENVELOPE_ALPHA_RST,
                         hold_samples:    ssc_pkg::HOLD_SAMPLES_RST};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssc_pkg::REG_INPUT_GAIN:
                begin
                    cfg_reg.input_gain <= cfg_data[ssc_pkg::GAIN_W-1:0];
                end
                ssc_pkg::REG_OUTPUT_LEVEL:
                begin
                    cfg_reg.output_level <= cfg_data[ssc_pkg::LEVEL_W-1:0];
                end
                ssc_pkg::REG_BASE_THRESHOLD:
                begin
                    cfg_reg.base_threshold <= cfg_data[ssc_pkg::THRESH_W-1:0];
                end
                ssc_pkg::REG_THRESHOLD_RATIO:
                begin
                    cfg_reg.threshold_ratio <= cfg_data[ssc_pkg::RATIO_W-1:0];
                end
                ssc_pkg::REG_PEAK_RELEASE:
                begin
                    cfg_reg.peak_release <= cfg_data[ssc_pkg::RELEASE_W-1:0];
                end
                ssc_pkg::REG_ENVELOPE_ALPHA:
                begin
                    cfg_reg.envelope_alpha <= cfg_data[ssc_pkg::ALPHA_W-1:0];
                end
                ssc_pkg::REG_HOLD_SAMPLES:
                begin
                    cfg_reg.hold_samples <= cfg_data[ssc_pkg::HOLD_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign ctrl.start    = in_valid && !stat.busy;
    assign ctrl.out_free = !out_valid_reg || !out_stall;

    ssc_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .sample_in (in_data),
        .stat      (stat),
        .result    (core_result)
    );

    // hold the result until the receiver takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_data_reg <= core_result;
        end
    end

    assign in_stall  = stat.busy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/ssc_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both divisions of the compressor.
// Depends on ssc_pkg for the request and response types.
`default_nettype none

module ssc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssc_pkg::div_req_t req,
    output ssc_pkg::div_rsp_t      rsp
);

    localparam int VW = ssc_pkg::VALUE_W;
    localparam int SW = ssc_pkg::STEP_W;

    logic          running_reg;
    logic [SW-1:0] count_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] low_reg;
    logic [VW-1:0] quot_reg;
    logic [VW-1:0] divisor_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] rem_next;

    assign trial    = {rem_reg, low_reg[VW-1]};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign diff     = trial - {1'b0, divisor_reg};
    assign rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (req.start)
        begin
            running_reg <= 1'b1;
        end
        else if (running_reg && (count_reg == SW'(1)))
        begin
            running_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            count_reg   <= req.steps;
            rem_reg     <= req.rem_init;
            low_reg     <= req.num_low;
            quot_reg    <= '0;
            divisor_reg <= req.divisor;
        end
        else if (running_reg)
        begin
            count_reg <= count_reg - SW'(1);
            rem_reg   <= rem_next;
            low_reg   <= {low_reg[VW-2:0], 1'b0};
            quot_reg  <= {quot_reg[VW-2:0], fits};
        end
    end

    assign rsp.busy     = running_reg;
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

// ----- sv/ssc_core.sv -----
// Sequencer and datapath of the compressor: one shared multiplier stepped by a state machine.
// Depends on ssc_pkg and instantiates ssc_div for the two divisions.
`default_nettype none

module ssc_core #(
    parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssc_pkg::cfg_t      cfg,
    input  wire ssc_pkg::ssc_ctrl_t ctrl,
    input  wire ssc_pkg::ssc_in_t   sample_in,
    output ssc_pkg::ssc_stat_t      stat,
    output ssc_pkg::ssc_out_t       result
);

    localparam int SW       = ssc_pkg::SAMPLE_W;
    localparam int VW       = ssc_pkg::VALUE_W;
    localparam int TW       = ssc_pkg::TIMER_W;
    localparam int STW      = ssc_pkg::STEP_W;
    localparam int MUL_W    = VW + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int G_W      = FRAC_BITS + 1;
    localparam int CAND_RAW = ssc_pkg::RATIO_W + VW - FRAC_BITS + 1;
    localparam int CAND_W   = (CAND_RAW > VW) ? CAND_RAW : VW;
    localparam int IN_LSH   = (FRAC_BITS >= SW - 1) ? FRAC_BITS - (SW - 1) : 0;
    localparam int IN_RSH   = (FRAC_BITS >= SW - 1) ? 0 : (SW - 1) - FRAC_BITS;
    localparam int OUT_RSH  = FRAC_BITS + IN_LSH;
    localparam int OUT_LSH  = IN_RSH;
    localparam int SAT_SH   = SW - 1 - OUT_LSH;

    localparam logic signed [PROD_W-1:0] SAT_ONE = PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_HI  = (SAT_ONE <<< SAT_SH) - SAT_ONE;
    localparam logic signed [PROD_W-1:0] SAT_LO  = -(SAT_ONE <<< SAT_SH);
    localparam logic signed [SW-1:0]     SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]     SMP_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic [G_W-1:0]           ONE_Q   = G_W'(1) << FRAC_BITS;
    localparam logic [STW-1:0]           STEPS_A = STW'(VW);
    localparam logic [STW-1:0]           STEPS_B = STW'(FRAC_BITS);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ML    = 5'd1;
    localparam logic [4:0] ST_MR    = 5'd2;
    localparam logic [4:0] ST_RGET  = 5'd3;
    localparam logic [4:0] ST_PEAK  = 5'd4;
    localparam logic [4:0] ST_HOLD  = 5'd5;
    localparam logic [4:0] ST_DECAY = 5'd6;
    localparam logic [4:0] ST_ENV2  = 5'd7;
    localparam logic [4:0] ST_ENV3  = 5'd8;
    localparam logic [4:0] ST_CMP   = 5'd9;
    localparam logic [4:0] ST_DIVA  = 5'd10;
    localparam logic [4:0] ST_DIVAW = 5'd11;
    localparam logic [4:0] ST_CVAL  = 5'd12;
    localparam logic [4:0] ST_DIVB  = 5'd13;
    localparam logic [4:0] ST_DIVBW = 5'd14;
    localparam logic [4:0] ST_GL    = 5'd15;
    localparam logic [4:0] ST_GR    = 5'd16;
    localparam logic [4:0] ST_LL    = 5'd17;
    localparam logic [4:0] ST_LR    = 5'd18;
    localparam logic [4:0] ST_RO    = 5'd19;
    localparam logic [4:0] ST_DONE  = 5'd20;

    logic [4:0] state_reg, state_next;

    logic signed [Q_W-1:0]    ql_reg, ql_next, qr_reg, qr_next;
    logic [G_W-1:0]           rel_reg, rel_next, alpha_reg, alpha_next, beta_reg, beta_next;
    logic [G_W-1:0]           gain_reg, gain_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [VW-1:0]     l_reg, l_next, r_reg, r_next;
    logic signed [VW-1:0]     lg_reg, lg_next, rg_reg, rg_next;
    logic [VW-1:0]            peak_reg, peak_next, env_reg, env_next, thr_reg, thr_next;
    logic [VW-1:0]            c_reg, c_next;
    logic [TW-1:0]            timer_reg, timer_next;
    logic                     decay_reg, decay_next, compress_reg, compress_next;
    logic [CAND_W-1:0]        cand_reg, cand_next;
    logic signed [SW-1:0]     lo_reg, lo_next, ro_reg, ro_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [VW:0]       mid_sum, mid, mag_full;
    logic [VW-1:0]            mag;
    logic signed [PROD_W-1:0] env_sum;
    logic [G_W-1:0]           rel_sel, alpha_sel;
    logic [CAND_W-1:0]        thr_pick, thr_low, thr_final;

    ssc_pkg::div_req_t div_req;
    ssc_pkg::div_rsp_t div_rsp;

    ssc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic signed [Q_W-1:0] to_q(input logic signed [SW-1:0] x);
        logic signed [MUL_W-1:0] w;
        w = MUL_W'(x);
        w = (w <<< IN_LSH) >>> IN_RSH;
        to_q = w[Q_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        logic signed [PROD_W-1:0] w;
        v = p >>> OUT_RSH;
        w = v <<< OUT_LSH;
        if (v > SAT_HI)
        begin
            sat_sample = SMP_MAX;
        end
        else if (v < SAT_LO)
        begin
            sat_sample = SMP_MIN;
        end
        else
        begin
            sat_sample = w[SW-1:0];
        end
    endfunction

    assign rel_sel   = (MUL_W'(cfg.peak_release) > MUL_W'(ONE_Q)) ?
                       ONE_Q : G_W'(cfg.peak_release);
    assign alpha_sel = (MUL_W'(cfg.envelope_alpha) > MUL_W'(ONE_Q)) ?
                       ONE_Q : G_W'(cfg.envelope_alpha);

    assign mid_sum  = {l_reg[VW-1], l_reg} + {r_reg[VW-1], r_reg};
    assign mid      = mid_sum >>> 1;
    assign mag_full = mid[VW] ? -mid : mid;
    assign mag      = mag_full[VW-1:0];
    assign env_sum  = acc_reg + prod_reg;

    assign thr_pick  = compress_reg ? cand_reg : CAND_W'(thr_reg);
    assign thr_low   = (CAND_W'(env_reg) < thr_pick) ? CAND_W'(env_reg) : thr_pick;
    assign thr_final = (thr_low < CAND_W'(cfg.base_threshold)) ?
                       CAND_W'(cfg.base_threshold) : thr_low;

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next    = state_reg;
        ql_next       = ql_reg;
        qr_next       = qr_reg;
        rel_next      = rel_reg;
        alpha_next    = alpha_reg;
        beta_next     = beta_reg;
        gain_next     = gain_reg;
        acc_next      = acc_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        lg_next       = lg_reg;
        rg_next       = rg_reg;
        peak_next     = peak_reg;
        env_next      = env_reg;
        thr_next      = thr_reg;
        c_next        = c_reg;
        timer_next    = timer_reg;
        decay_next    = decay_reg;
        compress_next = compress_reg;
        cand_next     = cand_reg;
        lo_next       = lo_reg;
        ro_next       = ro_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    ql_next    = to_q(sample_in.left_in);
                    qr_next    = to_q(sample_in.right_in);
                    rel_next   = rel_sel;
                    alpha_next = alpha_sel;
                    beta_next  = ONE_Q - alpha_sel;
                    state_next = ST_ML;
                end
            end
            ST_ML:
            begin
                mul_a      = MUL_W'(ql_reg);
                mul_b      = MUL_W'(cfg.input_gain);
                state_next = ST_MR;
            end
            ST_MR:
            begin
                l_next     = VW'(prod_reg >>> FRAC_BITS);
                mul_a      = MUL_W'(qr_reg);
                mul_b      = MUL_W'(cfg.input_gain);
                state_next = ST_RGET;
            end
            ST_RGET:
            begin
                r_next     = VW'(prod_reg >>> FRAC_BITS);
                state_next = ST_PEAK;
            end
            ST_PEAK:
            begin
                if (mag > peak_reg)
                begin
                    peak_next  = mag;
                    timer_next = '0;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (timer_reg > TW'(cfg.hold_samples))
                begin
                    decay_next = 1'b1;
                    mul_a      = MUL_W'(peak_reg);
                    mul_b      = MUL_W'(rel_reg);
                end
                else
                begin
                    decay_next = 1'b0;
                    timer_next = timer_reg + TW'(1);
                end
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                if (decay_reg)
                begin
                    peak_next = prod_reg[FRAC_BITS +: VW];
                end
                mul_a      = MUL_W'(beta_reg);
                mul_b      = MUL_W'(env_reg);
                state_next = ST_ENV2;
            end
            ST_ENV2:
            begin
                acc_next   = prod_reg;
                mul_a      = MUL_W'(alpha_reg);
                mul_b      = MUL_W'(peak_reg);
                state_next = ST_ENV3;
            end
            ST_ENV3:
            begin
                env_next   = env_sum[FRAC_BITS +: VW];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (env_reg > thr_reg)
                begin
                    compress_next = 1'b1;
                    mul_a         = MUL_W'(thr_reg);
                    mul_b         = MUL_W'(env_reg - thr_reg);
                    state_next    = ST_DIVA;
                end
                else
                begin
                    compress_next = 1'b0;
                    gain_next     = ONE_Q;
                    state_next    = ST_GL;
                end
            end
            ST_DIVA:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = prod_reg[2*VW-1:VW];
                div_req.num_low  = prod_reg[VW-1:0];
                div_req.divisor  = env_reg;
                div_req.steps    = STEPS_A;
                state_next       = ST_DIVAW;
            end
            ST_DIVAW:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = ST_CVAL;
                end
            end
            ST_CVAL:
            begin
                c_next     = thr_reg + div_rsp.quotient;
                mul_a      = MUL_W'(cfg.threshold_ratio);
                mul_b      = MUL_W'(div_rsp.quotient);
                state_next = ST_DIVB;
            end
            ST_DIVB:
            begin
                cand_next        = CAND_W'(cfg.base_threshold) +
                                   CAND_W'(prod_reg >>> FRAC_BITS);
                div_req.start    = 1'b1;
                div_req.rem_init = c_reg;
                div_req.num_low  = '0;
                div_req.divisor  = env_reg;
                div_req.steps    = STEPS_B;
                state_next       = ST_DIVBW;
            end
            ST_DIVBW:
            begin
                if (!div_rsp.busy)
                begin
                    gain_next  = div_rsp.quotient[G_W-1:0];
                    state_next = ST_GL;
                end
            end
            ST_GL:
            begin
                thr_next   = thr_final[VW-1:0];
                mul_a      = MUL_W'(l_reg);
                mul_b      = MUL_W'(gain_reg);
                state_next = ST_GR;
            end
            ST_GR:
            begin
                lg_next    = VW'(prod_reg >>> FRAC_BITS);
                mul_a      = MUL_W'(r_reg);
                mul_b      = MUL_W'(gain_reg);
                state_next = ST_LL;
            end
            ST_LL:
            begin
                rg_next    = VW'(prod_reg >>> FRAC_BITS);
                mul_a      = MUL_W'(lg_reg);
                mul_b      = MUL_W'(cfg.output_level);
                state_next = ST_LR;
            end
            ST_LR:
            begin
                lo_next    = sat_sample(prod_reg);
                mul_a      = MUL_W'(rg_reg);
                mul_b      = MUL_W'(cfg.output_level);
                state_next = ST_RO;
            end
            ST_RO:
            begin
                ro_next    = sat_sample(prod_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctrl.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            peak_reg  <= '0;
            env_reg   <= '0;
            thr_reg   <= VW'(ssc_pkg::BASE_THRESHOLD_RST);
            timer_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            peak_reg  <= peak_next;
            env_reg   <= env_next;
            thr_reg   <= thr_next;
            timer_reg <= timer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ql_reg       <= ql_next;
        qr_reg       <= qr_next;
        rel_reg      <= rel_next;
        alpha_reg    <= alpha_next;
        beta_reg     <= beta_next;
        gain_reg     <= gain_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        lg_reg       <= lg_next;
        rg_reg       <= rg_next;
        c_reg        <= c_next;
        decay_reg    <= decay_next;
        compress_reg <= compress_next;
        cand_reg     <= cand_next;
        lo_reg       <= lo_next;
        ro_reg       <= ro_next;
    end

    assign stat.busy        = (state_reg != ST_IDLE);
    assign stat.done        = (state_reg == ST_DONE) && ctrl.out_free;
    assign result.left_out  = lo_reg;
    assign result.right_out = ro_reg;

endmodule

`default_nettype wire
